FILE: design/shell_word_splitter_top_macros.svh
// Assertion macros for the shell word splitter checker.
// Included by the checker file only; no other dependencies.
`ifndef SHELL_WORD_SPLITTER_TOP_MACROS_SVH
`define SHELL_WORD_SPLITTER_TOP_MACROS_SVH

// Same-cycle implication, switched off while reset is high
`define SWS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high
`define SWS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/sws_pkg.sv
// Shared types and constants for the shell word splitter.
// Used by shell_word_splitter_top and its checker; no dependencies.
`timescale 1ns / 1ps

package sws_pkg;

   // result kinds
   typedef enum logic [2:0] {
      KIND_CHAR            = 3'd0,
      KIND_WORD_END        = 3'd1,
      KIND_LINE_DONE       = 3'd2,
      KIND_ABORT_EMPTY     = 3'd3,
      KIND_ABORT_INCOMPLETE = 3'd4,
      KIND_TOO_LONG        = 3'd5,
      KIND_BAD_CHAR        = 3'd6
   } kind_type;

   // one result word as held in the output queue
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  char_value;
      logic [6:0]  word_count;
      logic [15:0] line_number;
      logic        last;
   } result_type;

   // special characters
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0A;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;

   // quit character after reset (end-of-transmission)
   localparam logic [7:0] QUIT_RESET = 8'h04;

   // output queue: 8 entries; a new word is taken while fill plus
   // the reservation of the staged word stays within QUEUE_ADMIT
   localparam int unsigned QUEUE_AW    = 3;
   localparam int unsigned QUEUE_DEPTH = 1 << QUEUE_AW;
   localparam int unsigned QUEUE_CW    = QUEUE_AW + 1;
   localparam logic [QUEUE_CW-1:0] QUEUE_ADMIT = QUEUE_CW'(3);

endpackage

FILE: design/shell_word_splitter_top.sv
// Shell-style word splitter: input register, lexer decode, result queue.
// Depends on sws_pkg for result types, kinds and character constants.
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  req_in_char, req_end_of_input
// rsp       out        rsp_valid / rsp_stall  kind, char_value, word_count,
//                                             line_number, last
// csr       in         csr_valid / csr_ready  csr_quit_char
//
// A word is registered at acceptance and decoded in the next cycle; its
// results are written into the result queue, and rsp presents the queue head.
// One word per cycle is taken while rsp takes one result per cycle; a word
// end followed by line done gives two results and can raise req_stall.
// req_stall follows the fill level of the 8-entry result queue plus two
// entries held back for the staged word.
// Reset is synchronous and clears lexer state, counters and the queue.
// csr_ready is always high; the quit character is 4 after reset.
module shell_word_splitter_top #(
   parameter int unsigned BUF_BYTES = 1024,
   parameter int unsigned MAX_WORDS = 64
) (
   input  logic        clock,
   input  logic        reset,
   // input words
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_char,
   input  logic        req_end_of_input,
   // results
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_char_value,
   output logic [6:0]  rsp_word_count,
   output logic [15:0] rsp_line_number,
   output logic        rsp_last,
   // quit character register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_quit_char
);

   localparam int unsigned BW = $clog2(BUF_BYTES + 1);
   localparam int unsigned WW = (MAX_WORDS > 2) ? $clog2(MAX_WORDS) : 1;
   localparam logic [BW-1:0] BYTE_LIMIT_CHAR = BW'(BUF_BYTES - 1);
   localparam logic [BW-1:0] BYTE_LIMIT_END  = BW'(BUF_BYTES);
   localparam logic [WW-1:0] WORD_LIMIT      = WW'(MAX_WORDS - 1);

   typedef enum logic [3:0] {
      LX_GAP      = 4'd0,
      LX_GAP_ESC  = 4'd1,
      LX_WORD     = 4'd5,
      LX_WORD_ESC = 4'd6,
      LX_SQUOTE   = 4'd8,
      LX_DQUOTE   = 4'd10,
      LX_DQ_ESC   = 4'd12
   } lex_state_type;

   typedef enum logic [1:0] {
      ACT_MOVE,
      ACT_STORE,
      ACT_WORD_END,
      ACT_LINE
   } action_type;

   // control state
   lex_state_type           lex_ff, lex_in;
   logic [BW-1:0]           bytes_ff, bytes_in;
   logic [WW-1:0]           words_ff, words_in;
   logic [15:0]             line_ff, line_in;
   logic [7:0]              quit_ff;
   logic                    stage_valid_ff;
   logic [7:0]              stage_char_ff;
   logic                    stage_eoi_ff;
   logic [sws_pkg::QUEUE_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [sws_pkg::QUEUE_CW-1:0] count_ff;

   // result queue
   sws_pkg::result_type     queue_ff [sws_pkg::QUEUE_DEPTH];
   sws_pkg::result_type     res0, res1, head;
   logic [1:0]              push_n;
   logic [sws_pkg::QUEUE_AW-1:0] wr_ptr_nx;

   // decode
   lex_state_type           dec_state;
   action_type              dec_act;
   logic                    req_accept, rsp_pop;
   logic                    is_quit, is_bad, is_nl;
   logic [15:0]             line_next;
   logic [WW-1:0]           words_inc;
   logic [WW+6:0]           wc_cur_ext, wc_inc_ext;
   logic [6:0]              wc_cur, wc_inc;
   logic [sws_pkg::QUEUE_CW-1:0] reserve;

   // handshakes
   assign reserve    = stage_valid_ff ? sws_pkg::QUEUE_CW'(2) : '0;
   assign req_stall  = (count_ff + reserve) > sws_pkg::QUEUE_ADMIT;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (count_ff != '0);
   assign rsp_pop    = rsp_valid && !rsp_stall;
   assign csr_ready  = 1'b1;

   // classify the staged word
   assign is_quit   = stage_eoi_ff || (stage_char_ff == quit_ff);
   assign is_bad    = stage_char_ff[7];
   assign is_nl     = (stage_char_ff == sws_pkg::CH_NL) && !is_quit && !is_bad;
   assign line_next = line_ff + {15'd0, is_nl};

   // word counts as seven-bit fields
   assign words_inc  = words_ff + 1'b1;
   assign wc_cur_ext = {7'd0, words_ff};
   assign wc_inc_ext = {7'd0, words_inc};
   assign wc_cur     = wc_cur_ext[6:0];
   assign wc_inc     = wc_inc_ext[6:0];

   // lexer transition table
   always_comb begin
      dec_state = LX_WORD;
      dec_act   = ACT_STORE;
      case (lex_ff)
         LX_GAP_ESC: begin
            if (stage_char_ff == sws_pkg::CH_NL) begin
               dec_state = LX_GAP;
               dec_act   = ACT_MOVE;
            end
         end
         LX_WORD: begin
            if (stage_char_ff inside {sws_pkg::CH_SPACE, sws_pkg::CH_TAB,
                                      sws_pkg::CH_NL}) begin
               dec_state = LX_GAP;
               dec_act   = ACT_WORD_END;
            end else if (stage_char_ff == sws_pkg::CH_BSLASH) begin
               dec_state = LX_WORD_ESC;
               dec_act   = ACT_MOVE;
            end else if (stage_char_ff == sws_pkg::CH_SQUOTE) begin
               dec_state = LX_SQUOTE;
               dec_act   = ACT_MOVE;
            end else if (stage_char_ff == sws_pkg::CH_DQUOTE) begin
               dec_state = LX_DQUOTE;
               dec_act   = ACT_MOVE;
            end
         end
         LX_WORD_ESC: begin
            if (stage_char_ff == sws_pkg::CH_NL) begin
               dec_state = LX_WORD;
               dec_act   = ACT_MOVE;
            end
         end
         LX_SQUOTE: begin
            if (stage_char_ff == sws_pkg::CH_SQUOTE) begin
               dec_state = LX_WORD;
               dec_act   = ACT_MOVE;
            end else begin
               dec_state = LX_SQUOTE;
            end
         end
         LX_DQUOTE: begin
            if (stage_char_ff == sws_pkg::CH_DQUOTE) begin
               dec_state = LX_WORD;
               dec_act   = ACT_MOVE;
            end else if (stage_char_ff == sws_pkg::CH_BSLASH) begin
               dec_state = LX_DQ_ESC;
               dec_act   = ACT_MOVE;
            end else begin
               dec_state = LX_DQUOTE;
            end
         end
         LX_DQ_ESC: begin
            dec_state = LX_DQUOTE;
            if (stage_char_ff == sws_pkg::CH_NL) begin
               dec_act = ACT_MOVE;
            end
         end
         default: begin
            if (stage_char_ff inside {sws_pkg::CH_SPACE, sws_pkg::CH_TAB}) begin
               dec_state = LX_GAP;
               dec_act   = ACT_MOVE;
            end else if (stage_char_ff == sws_pkg::CH_NL) begin
               dec_state = LX_GAP;
               dec_act   = ACT_LINE;
            end else if (stage_char_ff == sws_pkg::CH_BSLASH) begin
               dec_state = LX_GAP_ESC;
               dec_act   = ACT_MOVE;
            end else if (stage_char_ff == sws_pkg::CH_SQUOTE) begin
               dec_state = LX_SQUOTE;
               dec_act   = ACT_MOVE;
            end else if (stage_char_ff == sws_pkg::CH_DQUOTE) begin
               dec_state = LX_DQUOTE;
               dec_act   = ACT_MOVE;
            end
         end
      endcase
   end

   // apply the staged word: results and next line state
   always_comb begin
      res0 = '{kind: sws_pkg::KIND_CHAR, char_value: 8'd0, word_count: wc_cur,
               line_number: line_next, last: 1'b1};
      res1 = '{kind: sws_pkg::KIND_LINE_DONE, char_value: 8'd0,
               word_count: wc_inc, line_number: line_next, last: 1'b1};
      push_n   = 2'd0;
      lex_in   = lex_ff;
      bytes_in = bytes_ff;
      words_in = words_ff;
      line_in  = line_ff;
      if (stage_valid_ff) begin
         line_in = line_next;
         push_n  = 2'd1;
         if (is_quit) begin
            // abort the line
            res0.kind = (words_ff != '0) ? sws_pkg::KIND_ABORT_INCOMPLETE
                                         : sws_pkg::KIND_ABORT_EMPTY;
            lex_in   = LX_GAP;
            bytes_in = '0;
            words_in = '0;
         end else if (is_bad) begin
            // skip the byte, keep state
            res0.kind = sws_pkg::KIND_BAD_CHAR;
         end else begin
            case (dec_act)
               ACT_STORE: begin
                  if (bytes_ff >= BYTE_LIMIT_CHAR || words_ff >= WORD_LIMIT) begin
                     res0.kind = sws_pkg::KIND_TOO_LONG;
                     lex_in    = LX_GAP;
                     bytes_in  = '0;
                     words_in  = '0;
                  end else begin
                     res0.char_value = stage_char_ff;
                     bytes_in        = bytes_ff + 1'b1;
                     lex_in          = dec_state;
                  end
               end
               ACT_WORD_END: begin
                  if (bytes_ff >= BYTE_LIMIT_END || words_ff >= WORD_LIMIT) begin
                     res0.kind = sws_pkg::KIND_TOO_LONG;
                     lex_in    = LX_GAP;
                     bytes_in  = '0;
                     words_in  = '0;
                  end else begin
                     res0.kind       = sws_pkg::KIND_WORD_END;
                     res0.word_count = wc_inc;
                     bytes_in        = bytes_ff + 1'b1;
                     words_in        = words_inc;
                     lex_in          = LX_GAP;
                     if (stage_char_ff == sws_pkg::CH_NL) begin
                        // word end then line done
                        res0.last = 1'b0;
                        push_n    = 2'd2;
                        bytes_in  = '0;
                        words_in  = '0;
                     end
                  end
               end
               ACT_LINE: begin
                  res0.kind = sws_pkg::KIND_LINE_DONE;
                  lex_in    = LX_GAP;
                  bytes_in  = '0;
                  words_in  = '0;
               end
               default: begin
                  push_n = 2'd0;
                  lex_in = dec_state;
               end
            endcase
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lex_ff         <= LX_GAP;
         bytes_ff       <= '0;
         words_ff       <= '0;
         line_ff        <= '0;
         quit_ff        <= sws_pkg::QUIT_RESET;
         stage_valid_ff <= 1'b0;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         count_ff       <= '0;
      end else begin
         lex_ff         <= lex_in;
         bytes_ff       <= bytes_in;
         words_ff       <= words_in;
         line_ff        <= line_in;
         stage_valid_ff <= req_accept;
         if (csr_valid && csr_ready) begin
            quit_ff <= csr_quit_char;
         end
         wr_ptr_ff <= wr_ptr_ff + sws_pkg::QUEUE_AW'(push_n);
         rd_ptr_ff <= rd_ptr_ff + sws_pkg::QUEUE_AW'(rsp_pop);
         count_ff  <= count_ff + sws_pkg::QUEUE_CW'(push_n)
                               - sws_pkg::QUEUE_CW'(rsp_pop);
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_char_ff <= req_in_char;
         stage_eoi_ff  <= req_end_of_input;
      end
   end

   // write results into the queue
   assign wr_ptr_nx = wr_ptr_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (push_n == 2'd2) begin
         queue_ff[wr_ptr_nx] <= res1;
      end
   end

   // present the queue head
   assign head            = queue_ff[rd_ptr_ff];
   assign rsp_kind        = head.kind;
   assign rsp_char_value  = head.char_value;
   assign rsp_word_count  = head.word_count;
   assign rsp_line_number = head.line_number;
   assign rsp_last        = head.last;

endmodule

FILE: design/sws_checker.sv
// Port-level checker for the shell word splitter, bound to the top level.
// Depends on sws_pkg and shell_word_splitter_top_macros.svh.
`timescale 1ns / 1ps
`include "shell_word_splitter_top_macros.svh"

module sws_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_kind,
   input logic [7:0] rsp_char_value,
   input logic       rsp_last
);

   // a stalled result holds
   `SWS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_kind) && $stable(rsp_char_value) && $stable(rsp_last), "stalled result changed")

   // character value only on word characters
   `SWS_ASSERT_NOW(a_char_zero, clock, reset, rsp_valid && (rsp_kind != sws_pkg::KIND_CHAR), rsp_char_value == 8'd0, "char_value set on non-character result")

   // no kind beyond bad char
   `SWS_ASSERT_NOW(a_kind_range, clock, reset, rsp_valid, rsp_kind <= sws_pkg::KIND_BAD_CHAR, "result kind out of range")

   // only a word end can be followed by a second result
   `SWS_ASSERT_NOW(a_single_last, clock, reset, rsp_valid && (rsp_kind != sws_pkg::KIND_WORD_END), rsp_last, "non-final result on a single-result kind")

   // a word end that is not last is followed at once by line done
   `SWS_ASSERT_NEXT(a_end_then_line, clock, reset, rsp_valid && !rsp_stall && (rsp_kind == sws_pkg::KIND_WORD_END) && !rsp_last, rsp_valid && (rsp_kind == sws_pkg::KIND_LINE_DONE) && rsp_last, "word end without following line done")

endmodule

bind shell_word_splitter_top sws_checker u_sws_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_kind       (rsp_kind),
   .rsp_char_value (rsp_char_value),
   .rsp_last       (rsp_last)
);

FILE: bench/shell_word_splitter_top_tb.sv
// Self-checking bench for shell_word_splitter_top: directed rows, then random command lines.
// Depends on sws_pkg for result types, kinds and characters, and on the RTL of the block.
`timescale 1ns / 1ps

module shell_word_splitter_top_tb;
   import sws_pkg::*;

   localparam int unsigned BUF_BYTES        = 1024;
   localparam int unsigned MAX_WORDS        = 64;
   localparam int          CYCLE_LIMIT      = 900000;
   localparam int          DRAIN_CYCLES     = 8;
   localparam int          RANDOM_PER_PHASE = 165;
   localparam int          NUM_PHASES       = 4;
   localparam logic [7:0]  CH_LOWER_A       = 8'h61;

   // lexer states and intermediate decode codes
   localparam logic [3:0] LX_GAP      = 4'd0;
   localparam logic [3:0] LX_GAP_ESC  = 4'd1;
   localparam logic [3:0] LX_BREAK    = 4'd2;
   localparam logic [3:0] LX_EOL      = 4'd3;
   localparam logic [3:0] LX_PUT_WORD = 4'd4;
   localparam logic [3:0] LX_WORD     = 4'd5;
   localparam logic [3:0] LX_WORD_ESC = 4'd6;
   localparam logic [3:0] LX_SQ       = 4'd8;
   localparam logic [3:0] LX_PUT_SQ   = 4'd9;
   localparam logic [3:0] LX_DQ       = 4'd10;
   localparam logic [3:0] LX_PUT_DQ   = 4'd11;
   localparam logic [3:0] LX_DQ_ESC   = 4'd12;

   typedef struct {
      logic [7:0] ch;
      logic       eof;
      logic       known;
      result_type want;
   } plan_row;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_in_char;
   logic        req_end_of_input;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_char_value;
   logic [6:0]  rsp_word_count;
   logic [15:0] rsp_line_number;
   logic        rsp_last;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_quit_char;

   // row tag travelling with the driven word
   logic        drv_known;
   result_type  drv_want;

   // splitter copy
   logic [7:0]  quit_q;
   logic [3:0]  lex_q;
   logic [10:0] bytes_q;
   logic [6:0]  words_q;
   logic [15:0] line_q;

   result_type  awaited_tokens[$];
   plan_row     plan[$];
   int          mismatch_count = 0;
   int          items_sent = 0;
   int          cycle_count;
   int          rx_hold;
   bit          calm = 1'b0;
   logic [7:0]  quit_now;

   shell_word_splitter_top #(
      .BUF_BYTES(BUF_BYTES),
      .MAX_WORDS(MAX_WORDS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_in_char(req_in_char),
      .req_end_of_input(req_end_of_input),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_char_value(rsp_char_value),
      .rsp_word_count(rsp_word_count),
      .rsp_line_number(rsp_line_number),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_quit_char(csr_quit_char)
   );

   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // next lexer code for one byte below 128
   function automatic logic [3:0] next_lexer(input logic [3:0] s, input logic [7:0] ch);
      case (s)
         LX_GAP_ESC: return (ch == CH_NL) ? LX_GAP : LX_PUT_WORD;
         LX_WORD: begin
            if (ch == CH_SPACE || ch == CH_TAB || ch == CH_NL) return LX_BREAK;
            if (ch == CH_BSLASH) return LX_WORD_ESC;
            if (ch == CH_SQUOTE) return LX_SQ;
            if (ch == CH_DQUOTE) return LX_DQ;
            return LX_PUT_WORD;
         end
         LX_WORD_ESC: return (ch == CH_NL) ? LX_WORD : LX_PUT_WORD;
         LX_SQ: return (ch == CH_SQUOTE) ? LX_WORD : LX_PUT_SQ;
         LX_DQ: begin
            if (ch == CH_DQUOTE) return LX_WORD;
            if (ch == CH_BSLASH) return LX_DQ_ESC;
            return LX_PUT_DQ;
         end
         LX_DQ_ESC: return (ch == CH_NL) ? LX_DQ : LX_PUT_DQ;
         default: begin
            if (ch == CH_SPACE || ch == CH_TAB) return LX_GAP;
            if (ch == CH_NL) return LX_EOL;
            if (ch == CH_BSLASH) return LX_GAP_ESC;
            if (ch == CH_SQUOTE) return LX_SQ;
            if (ch == CH_DQUOTE) return LX_DQ;
            return LX_PUT_WORD;
         end
      endcase
   endfunction

   function automatic result_type token(input kind_type kind, input logic [7:0] cv);
      result_type r;
      r.kind        = kind;
      r.char_value  = cv;
      r.word_count  = words_q;
      r.line_number = line_q;
      r.last        = 1'b0;
      return r;
   endfunction

   task automatic clear_line();
      lex_q   = LX_GAP;
      bytes_q = '0;
      words_q = '0;
   endtask

   // advance the splitter copy by one word; queue its tokens when asked
   task automatic split_byte(input logic [7:0] ch, input logic eof, input logic keep);
      result_type outs[2];
      int         n;
      logic [3:0] nxt;
      n = 0;
      if (eof || ch == quit_q) begin
         outs[0] = token(words_q != 0 ? KIND_ABORT_INCOMPLETE : KIND_ABORT_EMPTY, 8'h00);
         n = 1;
         clear_line();
      end else if (ch >= 8'h80) begin
         outs[0] = token(KIND_BAD_CHAR, 8'h00);
         n = 1;
      end else begin
         if (ch == CH_NL) line_q = line_q + 16'd1;
         nxt = next_lexer(lex_q, ch);
         if (nxt == LX_PUT_WORD || nxt == LX_PUT_SQ || nxt == LX_PUT_DQ) begin
            if (bytes_q >= BUF_BYTES - 1 || words_q >= MAX_WORDS - 1) begin
               outs[0] = token(KIND_TOO_LONG, 8'h00);
               n = 1;
               clear_line();
            end else begin
               bytes_q = bytes_q + 11'd1;
               outs[0] = token(KIND_CHAR, ch);
               n = 1;
               lex_q = (nxt == LX_PUT_WORD) ? LX_WORD : (nxt == LX_PUT_SQ) ? LX_SQ : LX_DQ;
            end
         end else if (nxt == LX_BREAK) begin
            if (bytes_q >= BUF_BYTES || words_q >= MAX_WORDS - 1) begin
               outs[0] = token(KIND_TOO_LONG, 8'h00);
               n = 1;
               clear_line();
            end else begin
               bytes_q = bytes_q + 11'd1;
               words_q = words_q + 7'd1;
               outs[0] = token(KIND_WORD_END, 8'h00);
               n = 1;
               if (ch == CH_NL) begin
                  outs[1] = token(KIND_LINE_DONE, 8'h00);
                  n = 2;
                  clear_line();
               end else begin
                  lex_q = LX_GAP;
               end
            end
         end else if (nxt == LX_EOL) begin
            outs[0] = token(KIND_LINE_DONE, 8'h00);
            n = 1;
            clear_line();
         end else begin
            lex_q = nxt;
         end
      end
      if (n > 0) outs[n-1].last = 1'b1;
      if (keep) begin
         for (int i = 0; i < n; i++) awaited_tokens.push_back(outs[i]);
      end
   endtask

   // predict on acceptance, check on delivery, draw the receiver hold-off
   always @(posedge clock) begin : scoreboard
      result_type got;
      result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         rx_hold = 0;
         quit_q  = QUIT_RESET;
         line_q  = '0;
         clear_line();
      end else begin
         if (csr_valid && csr_ready) quit_q = csr_quit_char;
         if (req_valid && !req_stall) begin
            split_byte(req_in_char, req_end_of_input, !drv_known);
            if (drv_known) awaited_tokens.push_back(drv_want);
         end
         if (rsp_valid && !rsp_stall) begin
            got.kind        = kind_type'(rsp_kind);
            got.char_value  = rsp_char_value;
            got.word_count  = rsp_word_count;
            got.line_number = rsp_line_number;
            got.last        = rsp_last;
            if (awaited_tokens.size() == 0) begin
               $display("%0t: unexpected word kind %0d char %h count %0d line %0d last %0b",
                        $time, got.kind, got.char_value, got.word_count, got.line_number,
                        got.last);
               mismatch_count++;
            end else begin
               want = awaited_tokens.pop_front();
               if (got !== want) begin
                  $display("%0t: expected kind %0d char %h count %0d line %0d last %0b",
                           $time, want.kind, want.char_value, want.word_count,
                           want.line_number, want.last);
                  $display("%0t:   actual kind %0d char %h count %0d line %0d last %0b",
                           $time, got.kind, got.char_value, got.word_count,
                           got.line_number, got.last);
                  mismatch_count++;
               end
            end
            rx_hold = calm ? 0 : $urandom_range(0, 13);
         end else if (rx_hold != 0) begin
            rx_hold--;
         end
         rsp_stall <= (rx_hold != 0);
      end
   end

   task automatic add_step(input logic [7:0] ch);
      plan_row r;
      r.ch    = ch;
      r.eof   = 1'b0;
      r.known = 1'b0;
      r.want  = '0;
      plan.push_back(r);
   endtask

   task automatic add_known(input logic [7:0] ch, input logic eof, input kind_type kind,
                            input logic [7:0] cv, input logic [6:0] wc,
                            input logic [15:0] ln);
      plan_row r;
      r.ch    = ch;
      r.eof   = eof;
      r.known = 1'b1;
      r.want.kind        = kind;
      r.want.char_value  = cv;
      r.want.word_count  = wc;
      r.want.line_number = ln;
      r.want.last        = 1'b1;
      plan.push_back(r);
   endtask

   // hold the word until the block takes it
   task automatic send_item(input logic [7:0] ch, input logic eof, input logic known,
                            input result_type want);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_in_char      <= ch;
      req_end_of_input <= eof;
      drv_known        <= known;
      drv_want         <= want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_byte(input logic [7:0] ch);
      send_item(ch, 1'b0, 1'b0, '0);
   endtask

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      if ($urandom_range(0, 4) != 0) return CH_LOWER_A + 8'($urandom_range(0, 25));
      do b = 8'($urandom_range(0, 127));
      while (b == CH_SPACE || b == CH_TAB || b == CH_NL || b == CH_BSLASH ||
             b == CH_SQUOTE || b == CH_DQUOTE);
      return b;
   endfunction

   function automatic logic [7:0] other_byte(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] v;
      do v = 8'($urandom_range(0, 127));
      while (v == a || v == b);
      return v;
   endfunction

   // one word built from plain, escaped, quoted and stray pieces
   task automatic send_word();
      int sel;
      repeat ($urandom_range(1, 4)) begin
         sel = $urandom_range(0, 9);
         if (sel == 5) begin
            send_byte(CH_BSLASH);
            send_byte($urandom_range(0, 3) == 0 ? CH_NL : 8'($urandom_range(0, 127)));
         end else if (sel == 6) begin
            send_byte(CH_SQUOTE);
            repeat ($urandom_range(0, 3)) send_byte(other_byte(CH_SQUOTE, CH_SQUOTE));
            send_byte(CH_SQUOTE);
         end else if (sel == 7) begin
            send_byte(CH_DQUOTE);
            repeat ($urandom_range(0, 3)) begin
               if ($urandom_range(0, 2) == 0) begin
                  send_byte(CH_BSLASH);
                  send_byte(8'($urandom_range(0, 127)));
               end else begin
                  send_byte(other_byte(CH_DQUOTE, CH_BSLASH));
               end
            end
            send_byte(CH_DQUOTE);
         end else if (sel == 8) begin
            send_byte(8'($urandom_range(128, 255)));
         end else begin
            send_byte(plain_byte());
         end
      end
   endtask

   // one command line: words, separators and a random kind of ending
   task automatic send_line();
      int nwords;
      int sel;
      calm = ($urandom_range(0, 3) == 0);
      nwords = ($urandom_range(0, 24) == 0) ? $urandom_range(60, 66) : $urandom_range(0, 5);
      for (int w = 0; w < nwords; w++) begin
         if (w > 0 || $urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 2)) send_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
         end
         if (nwords > 8) send_byte(plain_byte());
         else send_word();
      end
      sel = $urandom_range(0, 19);
      if (sel <= 13) begin
         send_byte(CH_NL);
      end else if (sel <= 15) begin
         send_byte(quit_now);
      end else if (sel == 16) begin
         send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
      end else if (sel == 17) begin
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
         send_byte(CH_NL);
      end else if (sel == 18) begin
         send_byte($urandom_range(0, 1) ? CH_SQUOTE : CH_BSLASH);
         repeat ($urandom_range(0, 2)) send_byte(plain_byte());
         send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
      end else begin
         repeat ($urandom_range(1, 3)) send_byte(CH_SPACE);
         send_byte(CH_NL);
      end
   endtask

   // wait for every token and the pipe to settle
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock);
      while (awaited_tokens.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_quit(input logic [7:0] value);
      drain();
      csr_valid     <= 1'b1;
      csr_quit_char <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      quit_now = value;
   endtask

   initial begin : stimulus
      int         phase_end;
      logic [7:0] q;
      req_valid        <= 1'b0;
      req_in_char      <= 8'h00;
      req_end_of_input <= 1'b0;
      drv_known        <= 1'b0;
      drv_want         <= '0;
      csr_valid        <= 1'b0;
      csr_quit_char    <= 8'h00;
      reset            <= 1'b1;
      quit_now = QUIT_RESET;

      // extremes, quoting forms, continuation, quit and empty lines
      add_known(8'h41, 1'b1, KIND_ABORT_EMPTY, 8'h00, 7'd0, 16'd0);
      add_known(8'hFF, 1'b0, KIND_BAD_CHAR, 8'h00, 7'd0, 16'd0);
      add_known(8'h80, 1'b0, KIND_BAD_CHAR, 8'h00, 7'd0, 16'd0);
      add_known(8'h00, 1'b0, KIND_CHAR, 8'h00, 7'd0, 16'd0);
      add_known(8'h7F, 1'b0, KIND_CHAR, 8'h7F, 7'd0, 16'd0);
      add_known(CH_SPACE, 1'b0, KIND_WORD_END, 8'h00, 7'd1, 16'd0);
      add_step(CH_LOWER_A);
      add_step(CH_SQUOTE);
      add_step(CH_SPACE);
      add_step(CH_BSLASH);
      add_step(CH_SQUOTE);
      add_step(CH_DQUOTE);
      add_step(CH_BSLASH);
      add_step(CH_DQUOTE);
      add_step(CH_BSLASH);
      add_step(CH_NL);
      add_step(CH_DQUOTE);
      add_step(CH_BSLASH);
      add_step(CH_NL);
      add_step(CH_TAB);
      add_known(QUIT_RESET, 1'b0, KIND_ABORT_INCOMPLETE, 8'h00, 7'd2, 16'd2);
      add_known(CH_NL, 1'b0, KIND_LINE_DONE, 8'h00, 7'd0, 16'd3);
      add_step(CH_BSLASH);
      add_step(CH_NL);
      add_step(CH_SQUOTE);
      add_step(CH_SQUOTE);
      add_step(CH_NL);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) send_item(plan[i].ch, plan[i].eof, plan[i].known, plan[i].want);

      // random lines under several quit settings, extremes first
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0:       q = 8'hFF;
            1:       q = 8'h00;
            2:       q = 8'($urandom_range(0, 255));
            default: q = QUIT_RESET;
         endcase
         set_quit(q);
         phase_end = items_sent + RANDOM_PER_PHASE;
         if (phase == 0) begin
            // one line near or past the byte capacity
            calm = 1'b1;
            repeat ($urandom_range(1015, 1030)) send_byte(plain_byte());
            send_byte(CH_NL);
            phase_end = items_sent + RANDOM_PER_PHASE;
         end
         while (items_sent < phase_end) send_line();
      end

      drain();
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

endmodule
